FILE: rtl/srfp_pkg.sv
// shared constants, types and helpers of the serial reply frame parser
`default_nettype none
package srfp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int FIXED_BYTES = 7;
  localparam int MAX_FRAME   = MAX_PAYLOAD + FIXED_BYTES;
  localparam int LEN_W       = $clog2(MAX_FRAME + 1);
  localparam int AW          = $clog2(MAX_PAYLOAD);

  localparam logic [7:0] START_CODE_RST = 8'd126;
  localparam logic [7:0] END_CODE_RST   = 8'd239;

  // configuration register indexes
  localparam logic [1:0] REG_START_CODE = 2'd0;
  localparam logic [1:0] REG_END_CODE   = 2'd1;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_SHORT     = 3'd1;
  localparam logic [2:0] STS_LONG      = 3'd2;
  localparam logic [2:0] STS_BAD_END   = 3'd3;
  localparam logic [2:0] STS_BAD_CKSUM = 3'd4;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] device_id;
    logic [7:0]  command;
    logic [5:0]  payload_length;
    logic [4:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        has_data;
    logic        last;
  } res_t;

  function automatic res_t err_res(input logic [2:0] st);
    res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/serial_reply_frame_parser_core.sv
// top level of the serial reply frame parser: framing, checksum and payload readout
`default_nettype none
// Serial reply frame parser. Each input beat carries one received byte. The block
// hunts for the start code, takes the next byte as the frame length L (7 to
// MAX_PAYLOAD+7), then collects device id (high byte first), command, L-7 payload
// bytes, checksum and end code. A bad length gives a status beat right away; a bad
// end code or checksum gives a status beat when the end code arrives. A good frame
// gives one result beat per payload byte (or a single beat for an empty payload).
// Input bytes are taken while the output register is free and no readout runs.
// Payload bytes sit in a 32x8 synchronous memory with a registered read; after a
// good frame the block reads them out one beat at a time (read, then load the
// output register once it is free) and holds the input off until the last beat
// is loaded. Error and empty-frame beats wait only for the output
// register. Configuration writes are taken at any time (cfg_ready is always high)
// and must only be issued while the block is idle.
module serial_reply_frame_parser_core (
  input  wire                  clk,
  input  wire                  rst_n,
  // input byte channel
  input  wire                  in_valid,
  output logic                 in_ready,
  input  srfp_pkg::byte_t      in_rx_byte,
  // result channel
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [2:0]           out_status,
  output logic [15:0]          out_device_id,
  output logic [7:0]           out_command,
  output logic [5:0]           out_payload_length,
  output logic [4:0]           out_byte_index,
  output logic [7:0]           out_payload_byte,
  output logic                 out_has_data,
  output logic                 out_last,
  // configuration write channel
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [1:0]           cfg_index,
  input  srfp_pkg::byte_t      cfg_data
);
  import srfp_pkg::*;

  // parser phases
  localparam logic [1:0] ST_HUNT = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_BODY = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  // body byte positions
  localparam logic [LEN_W-1:0] POS_ID_HI = LEN_W'(0);
  localparam logic [LEN_W-1:0] POS_ID_LO = LEN_W'(1);
  localparam logic [LEN_W-1:0] POS_CMD   = LEN_W'(2);
  localparam logic [LEN_W-1:0] POS_PL0   = LEN_W'(3);

  // configuration registers
  byte_t start_code_r, end_code_r;

  // frame state
  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  byte_t            sum_r, sum_nxt;
  byte_t            rsum_r, rsum_nxt;
  logic [15:0]      id_r, id_nxt;
  byte_t            cmd_r, cmd_nxt;

  // readout
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  // payload memory
  byte_t            mem [MAX_PAYLOAD];
  byte_t            mem_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;

  logic             in_fire, slot_free;
  logic [LEN_W:0]   pos_plus4;
  logic [LEN_W-1:0] plen;
  logic             rd_last;
  logic             rd_load;
  byte_t            b;

  assign b         = in_rx_byte;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r != ST_READ) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign pos_plus4 = {1'b0, cnt_r} + (LEN_W+1)'(4);
  assign plen      = len_r - LEN_W'(FIXED_BYTES);
  assign rd_last   = (rd_idx_r + LEN_W'(1)) == plen;
  assign rd_load   = (state_r == ST_READ) && rd_pend_r && slot_free;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      end_code_r   <= END_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_CODE: start_code_r <= cfg_data;
        REG_END_CODE:   end_code_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    rsum_nxt      = rsum_r;
    id_nxt        = id_r;
    cmd_nxt       = cmd_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_wa        = AW'(cnt_r - POS_PL0);

    case (state_r)
      ST_LEN: begin
        if (in_fire) begin
          if (b < 8'(FIXED_BYTES)) begin
            res_nxt       = err_res(STS_SHORT);
            out_valid_nxt = 1'b1;
            state_nxt     = ST_HUNT;
          end else if (b > 8'(MAX_FRAME)) begin
            res_nxt       = err_res(STS_LONG);
            out_valid_nxt = 1'b1;
            state_nxt     = ST_HUNT;
          end else begin
            len_nxt   = b[LEN_W-1:0];
            cnt_nxt   = '0;
            sum_nxt   = sum_r + b;
            state_nxt = ST_BODY;
          end
        end
      end

      ST_BODY: begin
        if (in_fire) begin
          cnt_nxt = cnt_r + LEN_W'(1);
          if (pos_plus4 < {1'b0, len_r}) begin
            // id, command or payload byte
            sum_nxt = sum_r + b;
            if (cnt_r == POS_ID_HI) begin
              id_nxt = {b, id_r[7:0]};
            end else if (cnt_r == POS_ID_LO) begin
              id_nxt = {id_r[15:8], b};
            end else if (cnt_r == POS_CMD) begin
              cmd_nxt = b;
            end else begin
              mem_we = 1'b1;
            end
          end else if (pos_plus4 == {1'b0, len_r}) begin
            rsum_nxt = b;
          end else begin
            // end code: check it first, then the checksum
            state_nxt = ST_HUNT;
            if (b != end_code_r) begin
              res_nxt       = err_res(STS_BAD_END);
              out_valid_nxt = 1'b1;
            end else if (rsum_r != sum_r) begin
              res_nxt       = err_res(STS_BAD_CKSUM);
              out_valid_nxt = 1'b1;
            end else if (plen == '0) begin
              res_nxt           = '0;
              res_nxt.status    = STS_OK;
              res_nxt.device_id = id_r;
              res_nxt.command   = cmd_r;
              res_nxt.last      = 1'b1;
              out_valid_nxt     = 1'b1;
            end else begin
              state_nxt   = ST_READ;
              rd_idx_nxt  = '0;
              rd_pend_nxt = 1'b0;
            end
          end
        end
      end

      ST_READ: begin
        // memory address follows rd_idx_r, data shows up registered in mem_q in the next cycle
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else if (rd_load) begin
          res_nxt.status         = STS_OK;
          res_nxt.device_id      = id_r;
          res_nxt.command        = cmd_r;
          res_nxt.payload_length = 6'(plen);
          res_nxt.byte_index     = 5'(rd_idx_r);
          res_nxt.payload_byte   = mem_q;
          res_nxt.has_data       = 1'b1;
          res_nxt.last           = rd_last;
          out_valid_nxt          = 1'b1;
          rd_idx_nxt             = rd_idx_r + LEN_W'(1);
          rd_pend_nxt            = 1'b0;
          if (rd_last) begin
            state_nxt = ST_HUNT;
          end
        end
      end

      default: begin
        // hunting for the start code
        if (in_fire && b == start_code_r) begin
          sum_nxt   = start_code_r;
          state_nxt = ST_LEN;
        end
      end
    endcase
  end

  // payload store: writes only while collecting; the read port reads every cycle,
  // but mem_q is used only during readout, after all writes of the frame
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= b;
    end
    mem_q <= mem[rd_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      len_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      rsum_r      <= '0;
      id_r        <= '0;
      cmd_r       <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      rsum_r      <= rsum_nxt;
      id_r        <= id_nxt;
      cmd_r       <= cmd_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_device_id      = res_r.device_id;
  assign out_command        = res_r.command;
  assign out_payload_length = res_r.payload_length;
  assign out_byte_index     = res_r.byte_index;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_has_data       = res_r.has_data;
  assign out_last           = res_r.last;

  // the final payload beat of a run ends the readout
  a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_load && rd_last) |=> (state_r == ST_HUNT))
    else $error("readout did not end after last beat");

  // an error beat is always a single beat with no data
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != STS_OK) |-> (res_r.last && !res_r.has_data))
    else $error("error beat not marked last or carries data");

  // data beats stay inside the payload
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.has_data) |-> ({1'b0, res_r.byte_index} < res_r.payload_length))
    else $error("byte index beyond payload length");

  // a pending memory read belongs to a readout
  a_pend_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_READ))
    else $error("memory read pending outside readout");

endmodule
`default_nettype wire
